// File: rtl/spmx_pkg.sv
// shared types and constants for the splitmix64 keystream xor block
package spmx_pkg;

    localparam logic [63:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] SEED_FOLD  = 64'h243F_6A88_85A3_08D3 + 64'h1319_8A2E_0370_7344;

    // register index, taken from paddr[3]
    localparam logic REG_SEED_PART_A = 1'b0;
    localparam logic REG_SEED_PART_B = 1'b1;

    // last partial product step of a 64x64 multiply
    localparam logic [1:0] MUL_LAST = 2'd2;

    typedef struct packed {
        logic [7:0] cipher;
        logic       first;
        logic       last;
        logic       need_key;
        logic [2:0] pos;
    } t_item;

endpackage

// File: rtl/spmx_front.sv
// front end: accepts cipher bytes, tracks key position, queues classified requests
module spmx_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_cipher_byte,
    input  logic                i_first_byte,
    input  logic                i_last_byte,
    output logic                o_push,
    output spmx_pkg::t_item     o_item,
    input  logic                i_full
);

    logic [2:0] r_byte_pos;
    logic [2:0] n_byte_pos;
    logic [2:0] n_pos_eff;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    // a first byte restarts at position zero
    assign n_pos_eff  = i_first_byte ? 3'd0 : r_byte_pos;
    assign n_byte_pos = i_last_byte ? 3'd0 : n_pos_eff + 3'd1;

    always_comb begin
        o_item.cipher   = i_cipher_byte;
        o_item.first    = i_first_byte;
        o_item.last     = i_last_byte;
        o_item.need_key = (n_pos_eff == 3'd0);
        o_item.pos      = n_pos_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= 3'd0;
        end else if (o_push) begin
            r_byte_pos <= n_byte_pos;
        end
    end

endmodule

// File: rtl/spmx_queue.sv
// small request queue between front end and keystream engine
module spmx_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  spmx_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output spmx_pkg::t_item  o_item,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    spmx_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

// File: rtl/spmx_back.sv
// keystream engine: splitmix64 step over a shared 32x32 multiplier, xor and output register
module spmx_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [63:0]      i_seed,
    input  logic             i_empty,
    output logic             o_pop,
    input  spmx_pkg::t_item  i_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_plain_byte,
    output logic             o_last_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV,
        S_MUL_A,
        S_MID,
        S_MUL_B,
        S_KEY
    } t_state;

    t_state          r_state;
    spmx_pkg::t_item r_item;
    logic [63:0]     r_gen_state;
    logic [63:0]     r_key_word;
    logic [63:0]     r_x;
    logic [63:0]     r_acc;
    logic [1:0]      r_step;
    logic            r_out_valid;
    logic [7:0]      r_plain_byte;
    logic            r_last_out;

    logic            n_slot_free;
    logic [63:0]     n_base;
    logic [63:0]     n_adv;
    logic [63:0]     n_const;
    logic [31:0]     n_mul_a;
    logic [31:0]     n_mul_b;
    logic [63:0]     n_prod;
    logic [63:0]     n_key;

    assign n_slot_free = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == S_IDLE) && !i_empty && n_slot_free;

    assign n_base = r_item.first ? i_seed : r_gen_state;
    assign n_adv  = n_base + spmx_pkg::GOLDEN_INC;
    assign n_key  = r_acc ^ (r_acc >> 31);

    // low 64 bits of x * c from three 32x32 partial products
    assign n_const = (r_state == S_MUL_B) ? spmx_pkg::MIX_MUL_B : spmx_pkg::MIX_MUL_A;

    always_comb begin
        case (r_step)
            2'd0: begin
                n_mul_a = r_x[31:0];
                n_mul_b = n_const[31:0];
            end
            2'd1: begin
                n_mul_a = r_x[63:32];
                n_mul_b = n_const[31:0];
            end
            default: begin
                n_mul_a = r_x[31:0];
                n_mul_b = n_const[63:32];
            end
        endcase
    end

    assign n_prod = {32'd0, n_mul_a} * {32'd0, n_mul_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_gen_state <= spmx_pkg::SEED_FOLD;
            r_step      <= 2'd0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_item <= i_item;
                        if (i_item.need_key) begin
                            r_state <= S_ADV;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_plain_byte <= i_item.cipher ^ r_key_word[i_item.pos*8 +: 8];
                            r_last_out   <= i_item.last;
                        end
                    end
                end
                S_ADV: begin
                    r_gen_state <= n_adv;
                    r_x         <= n_adv ^ (n_adv >> 30);
                    r_step      <= 2'd0;
                    r_state     <= S_MUL_A;
                end
                S_MUL_A, S_MUL_B: begin
                    if (r_step == 2'd0) begin
                        r_acc <= n_prod;
                    end else begin
                        r_acc <= r_acc + {n_prod[31:0], 32'd0};
                    end
                    if (r_step == spmx_pkg::MUL_LAST) begin
                        r_step  <= 2'd0;
                        r_state <= (r_state == S_MUL_A) ? S_MID : S_KEY;
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
                S_MID: begin
                    r_x     <= r_acc ^ (r_acc >> 27);
                    r_state <= S_MUL_B;
                end
                S_KEY: begin
                    r_key_word   <= n_key;
                    r_out_valid  <= 1'b1;
                    r_plain_byte <= r_item.cipher ^ n_key[r_item.pos*8 +: 8];
                    r_last_out   <= r_item.last;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_plain_byte = r_plain_byte;
    assign o_last_out   = r_last_out;

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("request popped while engine busy");

    a_slot_free_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("output register occupied during key generation");

endmodule

// File: rtl/splitmix64_keystream_xor_top.sv
// top level of the splitmix64 keystream xor decryptor with register port
// Decrypts a byte stream by xor with a splitmix64 keystream. Each request carries one cipher
// byte plus first and last flags and yields exactly one plain byte with the last flag copied.
// The generator seed is seed_part_a ^ seed_part_b ^ a fixed fold constant; a first-flagged
// byte reloads the generator from it, and register writes take effect only at the next first
// byte. Bytes that reuse the current key word are xored with the stored word. A byte that opens
// a key word (byte 0 of each group of eight, any first-flagged byte, the byte after a last byte)
// first advances the generator, then runs two 64-bit multiplies of three 32x32 partial products
// each through a single shared multiplier with a fold between them, and ends in a key/output
// step. A queue of QUEUE_DEPTH requests sits between the input side and the engine, so input
// keeps flowing while a key word is built until the queue fills; a one-entry output register
// decouples the output side. Registers are 64 bits at byte addresses 0 (seed_part_a) and 8
// (seed_part_b); pready is always high and reads return the register value.
module splitmix64_keystream_xor_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_cipher_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    // output requests
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_plain_byte,
    output logic        o_last_out,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0]     r_seed_part_a;
    logic [63:0]     r_seed_part_b;
    logic [63:0]     n_seed;
    logic            n_cfg_write;

    logic            n_push;
    logic            n_pop;
    logic            n_full;
    logic            n_empty;
    spmx_pkg::t_item n_push_item;
    spmx_pkg::t_item n_head_item;

    // register port: write on the access phase, zero wait states
    assign pready      = 1'b1;
    assign n_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_part_a <= 64'd0;
            r_seed_part_b <= 64'd0;
        end else if (n_cfg_write) begin
            case (paddr[3])
                spmx_pkg::REG_SEED_PART_A: r_seed_part_a <= pwdata;
                spmx_pkg::REG_SEED_PART_B: r_seed_part_b <= pwdata;
                default:                   r_seed_part_a <= r_seed_part_a;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            spmx_pkg::REG_SEED_PART_A: prdata = r_seed_part_a;
            spmx_pkg::REG_SEED_PART_B: prdata = r_seed_part_b;
            default:                   prdata = 64'd0;
        endcase
    end

    // combined generator seed
    assign n_seed = r_seed_part_a ^ r_seed_part_b ^ spmx_pkg::SEED_FOLD;

    // front end: position tracking and classification
    spmx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cipher_byte (i_cipher_byte),
        .i_first_byte  (i_first_byte),
        .i_last_byte   (i_last_byte),
        .o_push        (n_push),
        .o_item        (n_push_item),
        .i_full        (n_full)
    );

    // request queue
    spmx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_push),
        .i_item  (n_push_item),
        .o_full  (n_full),
        .i_pop   (n_pop),
        .o_item  (n_head_item),
        .o_empty (n_empty)
    );

    // keystream engine and output register
    spmx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (n_seed),
        .i_empty      (n_empty),
        .o_pop        (n_pop),
        .i_item       (n_head_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_plain_byte (o_plain_byte),
        .o_last_out   (o_last_out)
    );

endmodule
